FILE: design/mpid_pkg.sv
// shared types and constants for the multichannel pid controller
package mpid_pkg;

    localparam int CHANNELS       = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int CH_W           = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_PORT_W      = 4;
    localparam int CH_CMP_W       = 8;

    localparam int ERR_W   = 17;
    localparam int DERR_W  = 18;
    localparam int INTEG_W = 32;
    localparam int SUM_W   = 33;
    localparam int PP_W    = 33;
    localparam int PI_W    = 48;
    localparam int PD_W    = 34;
    localparam int TOTAL_W = 50;

    localparam int OUT_DEPTH = 8;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        OP_INIT = 1'b0,
        OP_CALC = 1'b1
    } op_t;

    typedef struct packed {
        logic signed [15:0]        gain_p;
        logic signed [15:0]        gain_i;
        logic signed [15:0]        gain_d;
        logic [30:0]               integral_limit;
        logic [15:0]               output_limit;
        logic signed [ERR_W-1:0]   prev_error;
        logic signed [INTEG_W-1:0] integral;
        logic                      first_pending;
    } chan_state_t;

    typedef struct packed {
        op_t                     op;
        logic                    in_range;
        logic [CH_W-1:0]         ch;
        logic signed [ERR_W-1:0] error;
        logic signed [15:0]      gain_p;
        logic signed [15:0]      gain_i;
        logic signed [15:0]      gain_d;
        logic [30:0]             integral_limit;
        logic [15:0]             output_limit;
    } item_t;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] addr;
        chan_state_t     data;
    } mem_wr_t;

endpackage

FILE: design/multichannel_pid_controller_core.sv
// top level of the multichannel pid controller
// an accepted request passes the datapath stage registers and is written to the result queue
// throughput: one request per cycle while in_ready is high; the state memory is read
// on accept and written back next cycle; a same-channel follow-up is served by bypass
// up to 8 requests in flight, held back by an in-flight count against the result queue
// reset clears control state and marks every channel unwritten, so state reads as zero
module multichannel_pid_controller_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [3:0]  channel,
    input  logic [15:0] setpoint,
    input  logic [15:0] measured,
    input  logic [15:0] gain_p,
    input  logic [15:0] gain_i,
    input  logic [15:0] gain_d,
    input  logic [30:0] integral_limit,
    input  logic [15:0] output_limit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] drive
);
    import mpid_pkg::*;

    logic              in_acc;
    logic              out_acc;
    logic [OCNT_W-1:0] inflight_reg;
    logic [OCNT_W-1:0] inflight_next;
    logic [CH_CMP_W-1:0] ch_ext;
    item_t             item;
    chan_state_t       rd_data;
    mem_wr_t           wr;
    logic              push;
    logic [15:0]       push_data;

    assign in_ready = (inflight_reg < OCNT_W'(OUT_DEPTH));
    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;

    always_comb
    begin
        ch_ext              = {{(CH_CMP_W-CH_PORT_W){1'b0}}, channel};
        item.op             = op_t'(op);
        item.in_range       = (ch_ext < CH_CMP_W'(CHANNELS));
        item.ch             = ch_ext[CH_W-1:0];
        item.error          = {setpoint[15], setpoint} - {measured[15], measured};
        item.gain_p         = gain_p;
        item.gain_i         = gain_i;
        item.gain_d         = gain_d;
        item.integral_limit = integral_limit;
        item.output_limit   = output_limit;

        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    mpid_state_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (item.ch),
        .wr      (wr),
        .rd_data (rd_data)
    );

    mpid_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_acc    (in_acc),
        .in_item   (item),
        .rd_data   (rd_data),
        .wr        (wr),
        .push      (push),
        .push_data (push_data)
    );

    mpid_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (out_acc),
        .not_empty (out_valid),
        .head      (drive)
    );

endmodule

FILE: design/mpid_state_mem.sv
// per-channel state memory, registered read, write-first bypass, reset by valid bits
module mpid_state_mem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [mpid_pkg::CH_W-1:0] rd_addr,
    input  mpid_pkg::mem_wr_t         wr,
    output mpid_pkg::chan_state_t     rd_data
);
    import mpid_pkg::*;

    chan_state_t           mem [CHANNELS];
    logic [CHANNELS-1:0]   valid_reg;
    chan_state_t           mem_q_reg;
    chan_state_t           wdata_q_reg;
    logic                  byp_reg;
    logic                  hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            mem_q_reg   <= mem[rd_addr];
            wdata_q_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            byp_reg   <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                byp_reg <= wr.en && (wr.addr == rd_addr);
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    // a write to the same entry in the same cycle as the read wins; unwritten entries read as zero
    always_comb
    begin
        if (byp_reg)
        begin
            rd_data = wdata_q_reg;
        end
        else if (hit_reg)
        begin
            rd_data = mem_q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

FILE: design/mpid_datapath.sv
// update stage, multiply stage and sum stage of the pid pipeline, then output scale and clamp
module mpid_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_acc,
    input  mpid_pkg::item_t       in_item,
    input  mpid_pkg::chan_state_t rd_data,
    output mpid_pkg::mem_wr_t     wr,
    output logic                  push,
    output logic [15:0]           push_data
);
    import mpid_pkg::*;

    // stage 1: item beside the state read
    logic  s1_valid_reg;
    item_t s1_item_reg;

    // stage 2: operands for the multipliers
    logic                       s2_valid_reg;
    logic                       s2_zero_reg;
    logic signed [ERR_W-1:0]    s2_err_reg;
    logic signed [DERR_W-1:0]   s2_derr_reg;
    logic signed [INTEG_W-1:0]  s2_integ_reg;
    logic signed [15:0]         s2_gp_reg;
    logic signed [15:0]         s2_gi_reg;
    logic signed [15:0]         s2_gd_reg;
    logic [15:0]                s2_olim_reg;

    // stage 3: products
    logic                    s3_valid_reg;
    logic                    s3_zero_reg;
    logic signed [PP_W-1:0]  s3_pp_reg;
    logic signed [PI_W-1:0]  s3_pi_reg;
    logic signed [PD_W-1:0]  s3_pd_reg;
    logic [15:0]             s3_olim_reg;

    // stage 4: total
    logic                       s4_valid_reg;
    logic                       s4_zero_reg;
    logic signed [TOTAL_W-1:0]  s4_total_reg;
    logic [15:0]                s4_olim_reg;

    logic                       zero_s1;
    logic signed [DERR_W-1:0]   derr_s1;
    logic signed [SUM_W-1:0]    sum_s1;
    logic signed [SUM_W-1:0]    lim_pos;
    logic signed [SUM_W-1:0]    lim_neg;
    logic signed [INTEG_W-1:0]  integ_s1;
    logic signed [TOTAL_W-1:0]  shifted;
    chan_state_t                new_state;

    always_comb
    begin
        derr_s1  = {s1_item_reg.error[ERR_W-1], s1_item_reg.error}
                 - {rd_data.prev_error[ERR_W-1], rd_data.prev_error};
        sum_s1   = {rd_data.integral[INTEG_W-1], rd_data.integral}
                 + {{(SUM_W-ERR_W){s1_item_reg.error[ERR_W-1]}}, s1_item_reg.error};
        lim_pos  = {2'b00, rd_data.integral_limit};
        lim_neg  = -lim_pos;
        if (sum_s1 > lim_pos)
        begin
            integ_s1 = lim_pos[INTEG_W-1:0];
        end
        else if (sum_s1 < lim_neg)
        begin
            integ_s1 = lim_neg[INTEG_W-1:0];
        end
        else
        begin
            integ_s1 = sum_s1[INTEG_W-1:0];
        end

        new_state = rd_data;
        zero_s1   = 1'b1;
        wr.en     = 1'b0;
        wr.addr   = s1_item_reg.ch;
        if (s1_valid_reg && s1_item_reg.in_range)
        begin
            wr.en = 1'b1;
            if (s1_item_reg.op == OP_INIT)
            begin
                new_state.gain_p         = s1_item_reg.gain_p;
                new_state.gain_i         = s1_item_reg.gain_i;
                new_state.gain_d         = s1_item_reg.gain_d;
                new_state.integral_limit = s1_item_reg.integral_limit;
                new_state.output_limit   = s1_item_reg.output_limit;
                new_state.prev_error     = '0;
                new_state.integral       = '0;
                new_state.first_pending  = 1'b1;
            end
            else if (rd_data.first_pending)
            begin
                new_state.prev_error    = s1_item_reg.error;
                new_state.first_pending = 1'b0;
            end
            else
            begin
                new_state.prev_error = s1_item_reg.error;
                new_state.integral   = integ_s1;
                zero_s1              = 1'b0;
            end
        end
        wr.data = new_state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_item_reg <= in_item;
        end
        s2_zero_reg  <= zero_s1;
        s2_err_reg   <= s1_item_reg.error;
        s2_derr_reg  <= derr_s1;
        s2_integ_reg <= integ_s1;
        s2_gp_reg    <= rd_data.gain_p;
        s2_gi_reg    <= rd_data.gain_i;
        s2_gd_reg    <= rd_data.gain_d;
        s2_olim_reg  <= rd_data.output_limit;

        s3_zero_reg <= s2_zero_reg;
        s3_pp_reg   <= s2_gp_reg * s2_err_reg;
        s3_pi_reg   <= s2_gi_reg * s2_integ_reg;
        s3_pd_reg   <= s2_gd_reg * s2_derr_reg;
        s3_olim_reg <= s2_olim_reg;

        s4_zero_reg  <= s3_zero_reg;
        s4_total_reg <= {{(TOTAL_W-PP_W){s3_pp_reg[PP_W-1]}}, s3_pp_reg}
                      + {{(TOTAL_W-PI_W){s3_pi_reg[PI_W-1]}}, s3_pi_reg}
                      + {{(TOTAL_W-PD_W){s3_pd_reg[PD_W-1]}}, s3_pd_reg};
        s4_olim_reg  <= s3_olim_reg;
    end

    // zero flag or non-positive total gives zero; else drop the fraction and clamp to the output limit
    always_comb
    begin
        shifted = s4_total_reg >>> GAIN_FRAC_BITS;
        if (s4_zero_reg || (s4_total_reg <= 0))
        begin
            push_data = '0;
        end
        else if ($unsigned(shifted) > {{(TOTAL_W-16){1'b0}}, s4_olim_reg})
        begin
            push_data = s4_olim_reg;
        end
        else
        begin
            push_data = shifted[15:0];
        end
        push = s4_valid_reg;
    end

endmodule

FILE: design/mpid_out_fifo.sv
// result queue in front of the output port
module mpid_out_fifo (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [15:0] push_data,
    input  logic        pop,
    output logic        not_empty,
    output logic [15:0] head
);
    import mpid_pkg::*;

    logic [15:0]       data_reg [OUT_DEPTH];
    logic [OPTR_W-1:0] wr_ptr_reg;
    logic [OPTR_W-1:0] rd_ptr_reg;
    logic [OCNT_W-1:0] count_reg;
    logic [OCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = data_reg[rd_ptr_reg];

endmodule
